// ===== rtl/tomasulo_issue_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Tomasulo issue scheduler
// Shorthand for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef TOMASULO_ISSUE_SCHEDULER_MACROS_SVH
`define TOMASULO_ISSUE_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define TIS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tomasulo_issue_scheduler: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define TIS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tomasulo_issue_scheduler: next-cycle check failed");

`endif

// ===== rtl/tis_pkg.sv =====
// ----------------------------------------------------------------------------
// Tomasulo issue scheduler package
// Codes, record types and operation tables shared by the scheduler.
// ----------------------------------------------------------------------------
package tis_pkg;

   // instruction phases
   localparam logic [2:0] PH_NONE    = 3'd0;
   localparam logic [2:0] PH_ISSUED  = 3'd1;
   localparam logic [2:0] PH_EXEC    = 3'd2;
   localparam logic [2:0] PH_DONE    = 3'd3;
   localparam logic [2:0] PH_WRITTEN = 3'd4;

   // event kinds
   localparam logic [2:0] EV_ISSUED    = 3'd0;
   localparam logic [2:0] EV_COMPLETED = 3'd1;
   localparam logic [2:0] EV_WRITTEN   = 3'd2;
   localparam logic [2:0] EV_CYCLE_END = 3'd3;
   localparam logic [2:0] EV_LOADED    = 3'd4;
   localparam logic [2:0] EV_FULL      = 3'd5;

   // station classes
   localparam logic [1:0] CLS_LOAD  = 2'd0;
   localparam logic [1:0] CLS_STORE = 2'd1;
   localparam logic [1:0] CLS_ADD   = 2'd2;
   localparam logic [1:0] CLS_MULT  = 2'd3;

   // operation codes
   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_MULT  = 3'd2;
   localparam logic [2:0] OP_DIV   = 3'd3;
   localparam logic [2:0] OP_LOAD  = 3'd4;
   localparam logic [2:0] OP_STR   = 3'd5;

   // configuration register indexes
   localparam logic [2:0] CSR_LOAD_STATIONS  = 3'd0;
   localparam logic [2:0] CSR_STORE_STATIONS = 3'd1;
   localparam logic [2:0] CSR_ADD_STATIONS   = 3'd2;
   localparam logic [2:0] CSR_MULT_STATIONS  = 3'd3;

   localparam logic [23:0] CYCLE_MAX = 24'hFFFFFF;

   typedef struct packed {
      logic [2:0] op;
      logic [4:0] dest;
      logic [4:0] src1;
      logic [4:0] src2;
   } trace_word_type;

   typedef struct packed {
      logic [2:0] phase;
      logic [5:0] remaining;
      logic [3:0] station;
   } inst_state_type;

   // tag bit 4 is the valid bit over a station id
   typedef struct packed {
      logic       ready;
      logic [4:0] tag;
   } reg_stat_type;

   function automatic logic [1:0] op_class(input logic [2:0] op);
      logic [1:0] c;
      case (op)
         OP_ADD, OP_SUB:   c = CLS_ADD;
         OP_LOAD:          c = CLS_LOAD;
         OP_STR:           c = CLS_STORE;
         default:          c = CLS_MULT;
      endcase
      return c;
   endfunction

   function automatic logic [5:0] op_latency(input logic [2:0] op);
      logic [5:0] l;
      case (op)
         OP_MULT:                              l = 6'd10;
         OP_ADD, OP_SUB, OP_LOAD, OP_STR:      l = 6'd2;
         default:                              l = 6'd40;
      endcase
      return l;
   endfunction

endpackage

// ===== rtl/tomasulo_issue_scheduler.sv =====
// ----------------------------------------------------------------------------
// Tomasulo issue scheduler
// Cycle-level timing model of Tomasulo scheduling with a trace store.
// ----------------------------------------------------------------------------
// An append (mode 0) answers one loaded or trace-full event in the next
// clock. An advance (mode 1) walks the fetched trace in program order
// through one shared evaluation step: it fetches, then for each fetched
// instruction reads its trace word and state and, if it is not yet written,
// reads the register status memory three times (dest, src1, src2) and
// commits; the single-port memories set this order. Results come one per
// strobe and cannot be stalled; the cycle-end event closes every advance.
// busy is high for the whole walk.
module tomasulo_issue_scheduler #(
   parameter int TRACE_DEPTH       = 64,
   parameter int FP_REGS           = 32,
   parameter int STATIONS_PER_TYPE = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [2:0]  req_op_code,
   input  logic [4:0]  req_dest_reg,
   input  logic [4:0]  req_src1_reg,
   input  logic [4:0]  req_src2_reg,
   output logic        rsp_valid,
   output logic [2:0]  rsp_event_kind,
   output logic [5:0]  rsp_instr_index,
   output logic [3:0]  rsp_station_id,
   output logic [23:0] rsp_event_cycle,
   output logic        rsp_all_done,
   output logic        rsp_last_event,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [2:0]  csr_data
);

`include "tomasulo_issue_scheduler_macros.svh"

   localparam int IW = $clog2(TRACE_DEPTH);
   localparam int CW = $clog2(TRACE_DEPTH + 1);
   localparam int AW = $clog2(FP_REGS);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_FA   = 4'd1;
   localparam logic [3:0] S_FB   = 4'd2;
   localparam logic [3:0] S_RA   = 4'd3;
   localparam logic [3:0] S_RB   = 4'd4;
   localparam logic [3:0] S_RC   = 4'd5;
   localparam logic [3:0] S_RD   = 4'd6;
   localparam logic [3:0] S_RE   = 4'd7;
   localparam logic [3:0] S_END  = 4'd8;

   function automatic logic [AW-1:0] reg_sat(input logic [4:0] r);
      if (32'(r) >= FP_REGS) return AW'(FP_REGS - 1);
      return AW'(r);
   endfunction

   function automatic logic [2:0] cnt_sat(input logic [2:0] c);
      if (32'(c) > STATIONS_PER_TYPE) return 3'(STATIONS_PER_TYPE);
      return c;
   endfunction

   // control state
   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] trace_count_ff, fetched_count_ff, walk_idx_ff;
   logic [23:0]   cycle_ff;
   logic          bus_free_ff, pending_ff, done_acc_ff;
   logic [2:0]    cfg_ff [4];
   logic [15:0]   busy_ff;
   logic [4:0]    src_tag_ff [8][2];
   logic [FP_REGS-1:0] rf_valid_ff;

   // memories and their read registers
   tis_pkg::trace_word_type trace_mem [TRACE_DEPTH];
   tis_pkg::inst_state_type ist_mem [TRACE_DEPTH];
   tis_pkg::reg_stat_type   rf_mem [FP_REGS];
   tis_pkg::trace_word_type trace_q_ff;
   tis_pkg::inst_state_type ist_q_ff;
   tis_pkg::reg_stat_type   rf_q_ff, rf_dest_ff, rf_s1_ff;
   logic                    rf_qv_ff;

   // result registers
   logic        rsp_valid_ff;
   logic [2:0]  rsp_kind_ff;
   logic [5:0]  rsp_index_ff;
   logic [3:0]  rsp_station_ff;
   logic [23:0] rsp_cycle_ff;
   logic        rsp_done_ff, rsp_last_ff;

   logic          accept, run_next, fetch_go;
   logic [CW-1:0] fetched_new;
   logic [IW-1:0] mem_rd_addr, walk_addr;
   logic          mem_rd_en;
   logic [AW-1:0] rf_rd_addr, dest_a;
   logic          rf_rd_en;

   // evaluation step signals
   logic [1:0]  cls;
   logic [2:0]  cnt;
   tis_pkg::reg_stat_type rf_s2;
   logic [2:0]  ph_n;
   logic [5:0]  rem_n;
   logic [3:0]  st_n;
   logic        ev_valid;
   logic [2:0]  ev_kind;
   logic        bcast, issue_ok, found, go;
   logic [1:0]  issue_k;
   logic [4:0]  btag, t1, t2, row1, row2;
   logic        rf_we;
   tis_pkg::reg_stat_type rf_wdata;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign walk_addr = walk_idx_ff[IW-1:0];
   assign run_next  = (walk_idx_ff + 1'b1) < fetched_count_ff;

   // fetch decision
   assign fetch_go = (fetched_count_ff < trace_count_ff) &&
                     ((fetched_count_ff == '0) || (ist_q_ff.phase != tis_pkg::PH_NONE));
   assign fetched_new = fetched_count_ff + CW'(fetch_go);

   // memory read ports
   always_comb begin
      mem_rd_en   = (state_ff == S_FA) || (state_ff == S_RA);
      mem_rd_addr = (state_ff == S_FA) ? IW'(fetched_count_ff - 1'b1) : walk_addr;
      rf_rd_en    = (state_ff == S_RB) || (state_ff == S_RC) || (state_ff == S_RD);
      case (state_ff)
         S_RC:    rf_rd_addr = reg_sat(trace_q_ff.src1);
         S_RD:    rf_rd_addr = reg_sat(trace_q_ff.src2);
         default: rf_rd_addr = reg_sat(trace_q_ff.dest);
      endcase
   end

   assign dest_a = reg_sat(trace_q_ff.dest);
   assign cls    = tis_pkg::op_class(trace_q_ff.op);
   assign cnt    = cnt_sat(cfg_ff[cls]);
   assign rf_s2  = rf_qv_ff ? rf_q_ff : '0;
   assign btag   = {1'b1, ist_q_ff.station};
   assign t1     = (rf_s1_ff.tag[4] && !rf_s1_ff.ready) ? rf_s1_ff.tag : '0;
   assign t2     = (rf_s2.tag[4] && !rf_s2.ready) ? rf_s2.tag : '0;

   // evaluate one instruction for this modeled cycle
   always_comb begin
      ph_n     = ist_q_ff.phase;
      rem_n    = ist_q_ff.remaining;
      st_n     = ist_q_ff.station;
      ev_valid = 1'b0;
      ev_kind  = tis_pkg::EV_ISSUED;
      bcast    = 1'b0;
      issue_ok = 1'b0;
      found    = 1'b0;
      issue_k  = '0;
      go       = 1'b0;
      row1     = '0;
      row2     = '0;
      // take the result bus
      if (ph_n == tis_pkg::PH_DONE && bus_free_ff) begin
         ph_n     = tis_pkg::PH_WRITTEN;
         bcast    = 1'b1;
         ev_valid = 1'b1;
         ev_kind  = tis_pkg::EV_WRITTEN;
      end
      // count down execution
      if (ph_n == tis_pkg::PH_EXEC) begin
         if (rem_n != '0) rem_n = rem_n - 1'b1;
         if (rem_n == '0) begin
            ph_n     = tis_pkg::PH_DONE;
            ev_valid = 1'b1;
            ev_kind  = tis_pkg::EV_COMPLETED;
         end
      end
      // issue into the lowest free station of the class
      if (ph_n == tis_pkg::PH_NONE) begin
         for (int k = 0; k < 4; k++) begin
            if (!found && (3'(k) < cnt) && !busy_ff[{cls, 2'(k)}]) begin
               found   = 1'b1;
               issue_k = 2'(k);
            end
         end
         if (found) begin
            issue_ok = 1'b1;
            ph_n     = tis_pkg::PH_ISSUED;
            st_n     = {cls, issue_k};
            ev_valid = 1'b1;
            ev_kind  = tis_pkg::EV_ISSUED;
         end
      end
      // start once operands are ready
      if (ph_n == tis_pkg::PH_ISSUED) begin
         if (cls[1]) begin
            row1 = issue_ok ? t1 : src_tag_ff[{cls[0], st_n[1:0]}][0];
            row2 = issue_ok ? t2 : src_tag_ff[{cls[0], st_n[1:0]}][1];
            go   = (row1 == '0) && (row2 == '0);
         end else if (cls == tis_pkg::CLS_STORE) begin
            go = !rf_dest_ff.tag[4] || rf_dest_ff.ready;
         end else begin
            go = 1'b1;
         end
         if (go) begin
            ph_n  = tis_pkg::PH_EXEC;
            rem_n = tis_pkg::op_latency(trace_q_ff.op);
         end
      end
      // register status write
      rf_we    = 1'b0;
      rf_wdata = rf_dest_ff;
      if (bcast && rf_dest_ff.tag == btag) begin
         rf_we    = 1'b1;
         rf_wdata = {1'b1, btag};
      end else if (issue_ok && cls != tis_pkg::CLS_STORE) begin
         rf_we    = 1'b1;
         rf_wdata = {1'b0, 1'b1, st_n};
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept && req_mode) state_in = S_FA;
         S_FA:    state_in = S_FB;
         S_FB:    state_in = (fetched_new != '0) ? S_RA : S_END;
         S_RA:    state_in = S_RB;
         S_RB: begin
            if (ist_q_ff.phase != tis_pkg::PH_WRITTEN) state_in = S_RC;
            else state_in = run_next ? S_RA : S_END;
         end
         S_RC:    state_in = S_RD;
         S_RD:    state_in = S_RE;
         S_RE:    state_in = run_next ? S_RA : S_END;
         S_END:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // memories: write and registered read
   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         trace_q_ff <= trace_mem[mem_rd_addr];
         ist_q_ff   <= ist_mem[mem_rd_addr];
      end
      if (rf_rd_en) begin
         rf_q_ff  <= rf_mem[rf_rd_addr];
         rf_qv_ff <= rf_valid_ff[rf_rd_addr];
      end
      if (state_ff == S_RC) rf_dest_ff <= rf_qv_ff ? rf_q_ff : '0;
      if (state_ff == S_RD) rf_s1_ff   <= rf_qv_ff ? rf_q_ff : '0;
      if (state_ff == S_IDLE && accept && !req_mode &&
          (32'(trace_count_ff) < TRACE_DEPTH)) begin
         trace_mem[IW'(trace_count_ff)] <= {req_op_code, req_dest_reg,
                                            req_src1_reg, req_src2_reg};
         ist_mem[IW'(trace_count_ff)]   <= {tis_pkg::PH_NONE, 6'd0, 4'd0};
      end
      if (state_ff == S_RE) begin
         ist_mem[walk_addr] <= {ph_n, rem_n, st_n};
         if (rf_we) rf_mem[dest_a] <= rf_wdata;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         trace_count_ff   <= '0;
         fetched_count_ff <= '0;
         walk_idx_ff      <= '0;
         cycle_ff         <= 24'd1;
         bus_free_ff      <= 1'b1;
         pending_ff       <= 1'b0;
         done_acc_ff      <= 1'b0;
         cfg_ff[0]        <= 3'd3;
         cfg_ff[1]        <= 3'd3;
         cfg_ff[2]        <= 3'd3;
         cfg_ff[3]        <= 3'd2;
         busy_ff          <= '0;
         rf_valid_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
         for (int r = 0; r < 8; r++) begin
            src_tag_ff[r][0] <= '0;
            src_tag_ff[r][1] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         // configuration writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tis_pkg::CSR_LOAD_STATIONS:  cfg_ff[0] <= csr_data;
               tis_pkg::CSR_STORE_STATIONS: cfg_ff[1] <= csr_data;
               tis_pkg::CSR_ADD_STATIONS:   cfg_ff[2] <= csr_data;
               tis_pkg::CSR_MULT_STATIONS:  cfg_ff[3] <= csr_data;
               default: ;
            endcase
         end
         // append transaction
         if (state_ff == S_IDLE && accept && !req_mode) begin
            rsp_valid_ff   <= 1'b1;
            rsp_station_ff <= '0;
            rsp_cycle_ff   <= cycle_ff;
            rsp_done_ff    <= 1'b0;
            rsp_last_ff    <= 1'b1;
            if (32'(trace_count_ff) < TRACE_DEPTH) begin
               rsp_kind_ff    <= tis_pkg::EV_LOADED;
               rsp_index_ff   <= 6'(trace_count_ff[IW-1:0]);
               trace_count_ff <= trace_count_ff + 1'b1;
            end else begin
               rsp_kind_ff  <= tis_pkg::EV_FULL;
               rsp_index_ff <= '0;
            end
         end
         // fetch and open the walk
         if (state_ff == S_FB) begin
            fetched_count_ff <= fetched_new;
            walk_idx_ff      <= '0;
            bus_free_ff      <= 1'b1;
            pending_ff       <= 1'b0;
            done_acc_ff      <= (fetched_new == trace_count_ff);
         end
         // skip written instructions
         if (state_ff == S_RB && ist_q_ff.phase == tis_pkg::PH_WRITTEN)
            walk_idx_ff <= walk_idx_ff + 1'b1;
         // commit one instruction
         if (state_ff == S_RE) begin
            walk_idx_ff <= walk_idx_ff + 1'b1;
            pending_ff  <= 1'b1;
            if (bcast) begin
               bus_free_ff                <= 1'b0;
               busy_ff[ist_q_ff.station]  <= 1'b0;
               for (int r = 0; r < 8; r++) begin
                  if (src_tag_ff[r][0] == btag) src_tag_ff[r][0] <= '0;
                  if (src_tag_ff[r][1] == btag) src_tag_ff[r][1] <= '0;
               end
            end
            if (issue_ok) begin
               busy_ff[st_n] <= 1'b1;
               if (cls[1]) begin
                  src_tag_ff[{cls[0], issue_k}][0] <= t1;
                  src_tag_ff[{cls[0], issue_k}][1] <= t2;
               end
            end
            if (rf_we) rf_valid_ff[dest_a] <= 1'b1;
            if (ph_n != tis_pkg::PH_WRITTEN) done_acc_ff <= 1'b0;
            if (ev_valid) begin
               rsp_valid_ff   <= 1'b1;
               rsp_kind_ff    <= ev_kind;
               rsp_index_ff   <= 6'(walk_addr);
               rsp_station_ff <= issue_ok ? st_n : ist_q_ff.station;
               rsp_cycle_ff   <= cycle_ff;
               rsp_done_ff    <= 1'b0;
               rsp_last_ff    <= 1'b0;
            end
         end
         // close the modeled cycle
         if (state_ff == S_END) begin
            rsp_valid_ff   <= 1'b1;
            rsp_kind_ff    <= tis_pkg::EV_CYCLE_END;
            rsp_index_ff   <= '0;
            rsp_station_ff <= '0;
            rsp_cycle_ff   <= cycle_ff;
            rsp_done_ff    <= done_acc_ff;
            rsp_last_ff    <= 1'b1;
            if (pending_ff && cycle_ff != tis_pkg::CYCLE_MAX)
               cycle_ff <= cycle_ff + 1'b1;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_instr_index = rsp_index_ff;
   assign rsp_station_id  = rsp_station_ff;
   assign rsp_event_cycle = rsp_cycle_ff;
   assign rsp_all_done    = rsp_done_ff;
   assign rsp_last_event  = rsp_last_ff;

   // checks
   `TIS_ASSERT_NXT(a_run_leaves_idle, clock, reset, start && !busy && req_mode, busy)
   `TIS_ASSERT_IMP(a_cycle_end_last, clock, reset, rsp_valid && rsp_event_kind == tis_pkg::EV_CYCLE_END, rsp_last_event)
   `TIS_ASSERT_IMP(a_walk_in_range, clock, reset, state_ff == S_RE, walk_idx_ff < fetched_count_ff)

endmodule

// ===== verif/tb_tomasulo_issue_scheduler.sv =====
// ----------------------------------------------------------------------------
// Testbench for the Tomasulo issue scheduler
// Builds instruction traces and advances the modelled machine cycle by cycle.
// Every event is compared against a cycle-level scheduling predictor.
// Station counts are swept through minimum, maximum, saturating and zero.
// ----------------------------------------------------------------------------
module tb_tomasulo_issue_scheduler;

   localparam logic       MODE_APPEND  = 1'b0;
   localparam logic       MODE_ADVANCE = 1'b1;
   localparam logic [2:0] OP_DIV_ALT6  = 3'd6;
   localparam logic [2:0] OP_DIV_ALT7  = 3'd7;
   localparam logic [2:0] CSR_UNUSED   = 3'd4;
   localparam int         TRACE_SLOTS  = 64;
   localparam int         IDLE_LIMIT   = 5000;
   localparam int         DIR_ROWS     = 21;

   typedef struct {
      logic [2:0]  kind;
      logic [5:0]  idx;
      logic [3:0]  st;
      logic [23:0] cyc;
      logic        done;
      logic        last;
   } sched_event_type;

   typedef struct packed {
      logic       mode;
      logic [2:0] op;
      logic [4:0] dest;
      logic [4:0] s1;
      logic [4:0] s2;
      logic       chk;
      logic [2:0] kind;
      logic [5:0] idx;
   } stim_row_type;

   logic        clock, reset, start, busy;
   logic        req_mode;
   logic [2:0]  req_op_code;
   logic [4:0]  req_dest_reg, req_src1_reg, req_src2_reg;
   logic        rsp_valid, rsp_all_done, rsp_last_event;
   logic [2:0]  rsp_event_kind;
   logic [5:0]  rsp_instr_index;
   logic [3:0]  rsp_station_id;
   logic [23:0] rsp_event_cycle;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index, csr_data;

   // scheduling state held by the predictor
   tis_pkg::trace_word_type trace_q [TRACE_SLOTS];
   logic [2:0]     phase_q [TRACE_SLOTS];
   logic [5:0]     remain_q [TRACE_SLOTS];
   logic [3:0]     stn_q [TRACE_SLOTS];
   logic           stn_busy [16];
   logic [4:0]     wait_tag [16];
   logic [4:0]     rtag [32];
   logic           rready [32];
   logic [2:0]     stn_count [4];
   int             trace_len, fetch_len;
   logic [23:0]    sim_cycle;
   logic           sched_done;

   sched_event_type sched_expect [$];
   sched_event_type first_ev;
   int              mismatches, idle_cycles;

   stim_row_type dir_rows [DIR_ROWS] = '{
      '{MODE_ADVANCE, tis_pkg::OP_ADD, 5'd0, 5'd0, 5'd0, 1'b1, tis_pkg::EV_CYCLE_END, 6'd0},
      '{MODE_APPEND, tis_pkg::OP_LOAD, 5'd1, 5'd0, 5'd0, 1'b1, tis_pkg::EV_LOADED, 6'd0},
      '{MODE_APPEND, tis_pkg::OP_LOAD, 5'd31, 5'd31, 5'd31, 1'b1, tis_pkg::EV_LOADED, 6'd1},
      '{MODE_APPEND, tis_pkg::OP_MULT, 5'd3, 5'd1, 5'd31, 1'b1, tis_pkg::EV_LOADED, 6'd2},
      '{MODE_APPEND, tis_pkg::OP_ADD, 5'd4, 5'd3, 5'd31, 1'b1, tis_pkg::EV_LOADED, 6'd3},
      '{MODE_APPEND, tis_pkg::OP_SUB, 5'd0, 5'd4, 5'd4, 1'b1, tis_pkg::EV_LOADED, 6'd4},
      '{MODE_APPEND, tis_pkg::OP_STR, 5'd4, 5'd0, 5'd0, 1'b1, tis_pkg::EV_LOADED, 6'd5},
      '{MODE_APPEND, tis_pkg::OP_DIV, 5'd5, 5'd0, 5'd3, 1'b1, tis_pkg::EV_LOADED, 6'd6},
      '{MODE_APPEND, OP_DIV_ALT6, 5'd6, 5'd5, 5'd5, 1'b1, tis_pkg::EV_LOADED, 6'd7},
      '{MODE_APPEND, OP_DIV_ALT7, 5'd7, 5'd6, 5'd31, 1'b1, tis_pkg::EV_LOADED, 6'd8},
      '{MODE_APPEND, tis_pkg::OP_STR, 5'd7, 5'd0, 5'd0, 1'b1, tis_pkg::EV_LOADED, 6'd9},
      '{MODE_ADVANCE, tis_pkg::OP_ADD, 5'd0, 5'd0, 5'd0, 1'b0, tis_pkg::EV_ISSUED, 6'd0},
      '{MODE_ADVANCE, tis_pkg::OP_ADD, 5'd0, 5'd0, 5'd0, 1'b0, tis_pkg::EV_ISSUED, 6'd0},
      '{MODE_ADVANCE, tis_pkg::OP_ADD, 5'd0, 5'd0, 5'd0, 1'b0, tis_pkg::EV_ISSUED, 6'd0},
      '{MODE_ADVANCE, tis_pkg::OP_ADD, 5'd0, 5'd0, 5'd0, 1'b0, tis_pkg::EV_ISSUED, 6'd0},
      '{MODE_ADVANCE, tis_pkg::OP_ADD, 5'd0, 5'd0, 5'd0, 1'b0, tis_pkg::EV_ISSUED, 6'd0},
      '{MODE_ADVANCE, tis_pkg::OP_ADD, 5'd0, 5'd0, 5'd0, 1'b0, tis_pkg::EV_ISSUED, 6'd0},
      '{MODE_ADVANCE, tis_pkg::OP_ADD, 5'd0, 5'd0, 5'd0, 1'b0, tis_pkg::EV_ISSUED, 6'd0},
      '{MODE_ADVANCE, tis_pkg::OP_ADD, 5'd0, 5'd0, 5'd0, 1'b0, tis_pkg::EV_ISSUED, 6'd0},
      '{MODE_ADVANCE, tis_pkg::OP_ADD, 5'd0, 5'd0, 5'd0, 1'b0, tis_pkg::EV_ISSUED, 6'd0},
      '{MODE_ADVANCE, tis_pkg::OP_ADD, 5'd0, 5'd0, 5'd0, 1'b0, tis_pkg::EV_ISSUED, 6'd0}
   };

   tomasulo_issue_scheduler u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_op_code(req_op_code), .req_dest_reg(req_dest_reg),
      .req_src1_reg(req_src1_reg), .req_src2_reg(req_src2_reg),
      .rsp_valid(rsp_valid), .rsp_event_kind(rsp_event_kind),
      .rsp_instr_index(rsp_instr_index), .rsp_station_id(rsp_station_id),
      .rsp_event_cycle(rsp_event_cycle), .rsp_all_done(rsp_all_done),
      .rsp_last_event(rsp_last_event),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // station class and execution time of each opcode
   function automatic logic [1:0] class_of(input logic [2:0] op);
      case (op)
         tis_pkg::OP_ADD, tis_pkg::OP_SUB: return tis_pkg::CLS_ADD;
         tis_pkg::OP_LOAD:                 return tis_pkg::CLS_LOAD;
         tis_pkg::OP_STR:                  return tis_pkg::CLS_STORE;
         default:                          return tis_pkg::CLS_MULT;
      endcase
   endfunction

   function automatic logic [5:0] exec_cycles(input logic [2:0] op);
      case (op)
         tis_pkg::OP_MULT: return 6'd10;
         tis_pkg::OP_ADD, tis_pkg::OP_SUB, tis_pkg::OP_LOAD, tis_pkg::OP_STR: return 6'd2;
         default:          return 6'd40;
      endcase
   endfunction

   function automatic void log_event(input logic [2:0] kind, input int idx,
                                     input logic [3:0] st, input logic done);
      sched_event_type ev;
      ev.kind = kind;
      ev.idx  = idx[5:0];
      ev.st   = st;
      ev.cyc  = sim_cycle;
      ev.done = done;
      ev.last = 1'b0;
      sched_expect.insert(sched_expect.size(), ev);
   endfunction

   // claim the lowest free station of a class; -1 when all are taken
   function automatic int claim_station(input logic [1:0] cls, input logic [4:0] d,
                                        input logic [4:0] s1, input logic [4:0] s2);
      int cnt, id, w;
      cnt = (stn_count[cls] > 4) ? 4 : stn_count[cls];
      for (int k = 0; k < cnt; k++) begin
         id = cls * 4 + k;
         if (stn_busy[id]) continue;
         stn_busy[id] = 1'b1;
         if (cls >= tis_pkg::CLS_ADD) begin
            w = (cls - tis_pkg::CLS_ADD) * 8 + k * 2;
            wait_tag[w]     = (rtag[s1][4] && !rready[s1]) ? rtag[s1] : 5'd0;
            wait_tag[w + 1] = (rtag[s2][4] && !rready[s2]) ? rtag[s2] : 5'd0;
         end
         if (cls != tis_pkg::CLS_STORE) begin
            rready[d] = 1'b0;
            rtag[d]   = {1'b1, id[3:0]};
         end
         return id;
      end
      return -1;
   endfunction

   // work out the events one accepted transaction causes
   function automatic void sched_predict(input logic mode, input tis_pkg::trace_word_type w);
      logic        pending, bus_free, go;
      logic [1:0]  cls;
      logic [3:0]  st;
      logic [4:0]  tag;
      int          id, k, base;
      tis_pkg::trace_word_type t;
      pending  = 1'b0;
      bus_free = 1'b1;
      base     = sched_expect.size();
      if (mode == MODE_APPEND) begin
         if (trace_len >= TRACE_SLOTS) log_event(tis_pkg::EV_FULL, 0, 4'd0, 1'b0);
         else begin
            trace_q[trace_len] = w;
            phase_q[trace_len] = tis_pkg::PH_NONE;
            log_event(tis_pkg::EV_LOADED, trace_len, 4'd0, 1'b0);
            trace_len++;
         end
         sched_expect[$].last = 1'b1;
         first_ev = sched_expect[base];
         return;
      end
      if (fetch_len < trace_len &&
          (fetch_len == 0 || phase_q[fetch_len - 1] != tis_pkg::PH_NONE))
         fetch_len++;
      for (int i = 0; i < fetch_len; i++) begin
         t   = trace_q[i];
         cls = class_of(t.op);
         st  = stn_q[i];
         if (phase_q[i] == tis_pkg::PH_WRITTEN) continue;
         pending = 1'b1;
         // single result bus: first finished instruction broadcasts
         if (phase_q[i] == tis_pkg::PH_DONE) begin
            if (!bus_free) continue;
            bus_free   = 1'b0;
            phase_q[i] = tis_pkg::PH_WRITTEN;
            tag = {1'b1, st};
            if (rtag[t.dest] == tag) rready[t.dest] = 1'b1;
            for (int j = 0; j < 16; j++)
               if (wait_tag[j] == tag) wait_tag[j] = 5'd0;
            stn_busy[st] = 1'b0;
            log_event(tis_pkg::EV_WRITTEN, i, st, 1'b0);
         end
         if (phase_q[i] == tis_pkg::PH_EXEC) begin
            if (remain_q[i] > 0) remain_q[i]--;
            if (remain_q[i] == 0) begin
               phase_q[i] = tis_pkg::PH_DONE;
               log_event(tis_pkg::EV_COMPLETED, i, st, 1'b0);
            end
         end
         if (phase_q[i] == tis_pkg::PH_NONE) begin
            id = claim_station(cls, t.dest, t.src1, t.src2);
            if (id >= 0) begin
               phase_q[i] = tis_pkg::PH_ISSUED;
               stn_q[i]   = id[3:0];
               st         = id[3:0];
               log_event(tis_pkg::EV_ISSUED, i, st, 1'b0);
            end
         end
         if (phase_q[i] == tis_pkg::PH_ISSUED) begin
            if (cls >= tis_pkg::CLS_ADD) begin
               k  = (cls - tis_pkg::CLS_ADD) * 8 + st[1:0] * 2;
               go = wait_tag[k] == 5'd0 && wait_tag[k + 1] == 5'd0;
            end else if (cls == tis_pkg::CLS_STORE) go = !rtag[t.dest][4] || rready[t.dest];
            else go = 1'b1;
            if (go) begin
               phase_q[i]  = tis_pkg::PH_EXEC;
               remain_q[i] = exec_cycles(t.op);
            end
         end
      end
      sched_done = fetch_len == trace_len;
      for (int i = 0; i < trace_len; i++)
         if (phase_q[i] != tis_pkg::PH_WRITTEN) sched_done = 1'b0;
      log_event(tis_pkg::EV_CYCLE_END, 0, 4'd0, sched_done);
      sched_expect[$].last = 1'b1;
      first_ev = sched_expect[base];
      if (pending && sim_cycle < tis_pkg::CYCLE_MAX) sim_cycle++;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // random instruction, mostly over a narrow register range to build dependencies
   function automatic tis_pkg::trace_word_type rand_word();
      tis_pkg::trace_word_type w;
      w.op = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) begin
         w.dest = 5'($urandom); w.src1 = 5'($urandom); w.src2 = 5'($urandom);
      end else begin
         w.dest = 5'($urandom_range(0, 5)); w.src1 = 5'($urandom_range(0, 5));
         w.src2 = 5'($urandom_range(0, 5));
      end
      return w;
   endfunction

   // drive one transaction; start stays high when no gap follows
   task automatic send_item(input logic mode, input tis_pkg::trace_word_type w,
                            input int gap);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start        <= 1'b1;
      req_mode     <= mode;
      req_op_code  <= w.op;
      req_dest_reg <= w.dest;
      req_src1_reg <= w.src1;
      req_src2_reg <= w.src2;
      do @(posedge clock); while (busy);
      sched_predict(mode, w);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (sched_expect.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [2:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index <= tis_pkg::CSR_MULT_STATIONS) stn_count[index[1:0]] = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      logic mode;
      mode = ($urandom_range(0, 99) < 35) ? MODE_APPEND : MODE_ADVANCE;
      send_item(mode, rand_word(), pick_gap());
   endtask

   // compare each strobed event with the oldest expectation
   always @(posedge clock) begin
      sched_event_type exp_ev;
      if (!reset && rsp_valid) begin
         if (sched_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected event kind %0d index %0d",
                        rsp_event_kind, rsp_instr_index);
         end else begin
            exp_ev = sched_expect.pop_front();
            if (rsp_event_kind !== exp_ev.kind || rsp_instr_index !== exp_ev.idx ||
                rsp_station_id !== exp_ev.st || rsp_event_cycle !== exp_ev.cyc ||
                rsp_all_done !== exp_ev.done || rsp_last_event !== exp_ev.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"event mismatch exp k%0d i%0d s%0d c%0d d%0d l%0d",
                            " got k%0d i%0d s%0d c%0d d%0d l%0d"},
                           exp_ev.kind, exp_ev.idx, exp_ev.st, exp_ev.cyc, exp_ev.done,
                           exp_ev.last, rsp_event_kind, rsp_instr_index, rsp_station_id,
                           rsp_event_cycle, rsp_all_done, rsp_last_event);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      tis_pkg::trace_word_type w;
      reset = 1'b1; start = 1'b0; req_mode = MODE_APPEND; req_op_code = tis_pkg::OP_ADD;
      req_dest_reg = 5'd0; req_src1_reg = 5'd0; req_src2_reg = 5'd0;
      csr_valid = 1'b0; csr_index = tis_pkg::CSR_LOAD_STATIONS; csr_data = 3'd0;
      mismatches = 0; idle_cycles = 0;
      trace_len = 0; fetch_len = 0; sim_cycle = 24'd1; sched_done = 1'b0;
      for (int i = 0; i < TRACE_SLOTS; i++) begin
         phase_q[i] = tis_pkg::PH_NONE; remain_q[i] = '0; stn_q[i] = '0; trace_q[i] = '0;
      end
      for (int i = 0; i < 16; i++) begin
         stn_busy[i] = 1'b0; wait_tag[i] = '0;
      end
      for (int i = 0; i < 32; i++) begin
         rtag[i] = '0; rready[i] = 1'b0;
      end
      stn_count[0] = 3'd3; stn_count[1] = 3'd3; stn_count[2] = 3'd3; stn_count[3] = 3'd2;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows at reset settings; typed results cross-check the predictor
      for (int r = 0; r < DIR_ROWS; r++) begin
         w = '{dir_rows[r].op, dir_rows[r].dest, dir_rows[r].s1, dir_rows[r].s2};
         send_item(dir_rows[r].mode, w, r % 3);
         if (dir_rows[r].chk && (first_ev.kind !== dir_rows[r].kind ||
                                 first_ev.idx !== dir_rows[r].idx)) begin
            mismatches++;
            if (mismatches <= 10)
               $display("directed row %0d exp k%0d i%0d got k%0d i%0d", r,
                        dir_rows[r].kind, dir_rows[r].idx, first_ev.kind, first_ev.idx);
         end
      end

      // random phases, each under its own station setting
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         case (ph)
            0: for (int c = 0; c < 4; c++) write_csr(c[2:0], 3'd1);
            1: for (int c = 0; c < 4; c++) write_csr(c[2:0], 3'd4);
            2: begin
               write_csr(tis_pkg::CSR_LOAD_STATIONS, 3'd7);
               write_csr(tis_pkg::CSR_STORE_STATIONS, 3'd6);
               write_csr(tis_pkg::CSR_ADD_STATIONS, 3'd0);
               write_csr(tis_pkg::CSR_MULT_STATIONS, 3'd5);
               write_csr(CSR_UNUSED | 3'($urandom_range(0, 3)), 3'd0);
            end
            default: for (int c = 0; c < 4; c++) write_csr(c[2:0], 3'($urandom_range(1, 4)));
         endcase
         repeat (8) random_item();
      end

      // fill the trace past its depth, then advance a few cycles
      drain();
      write_csr(tis_pkg::CSR_ADD_STATIONS, 3'd2);
      while (trace_len < TRACE_SLOTS) send_item(MODE_APPEND, rand_word(), pick_gap());
      w = '{tis_pkg::OP_ADD, 5'd31, 5'd31, 5'd31};
      repeat (2) send_item(MODE_APPEND, w, pick_gap());
      repeat (6) send_item(MODE_ADVANCE, w, pick_gap());
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && sched_expect.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
